// ----- design/weighted_reservoir_picker_unit_assert.svh -----
// Assertion macros used by wrp_back.
// WRP_ASSERT_IMP checks that a condition holds in the same cycle as its trigger.
// WRP_ASSERT_NXT checks that a condition holds in the cycle after its trigger.
// Defining ASSERT_OFF turns both macros into empty text.
`ifndef WEIGHTED_RESERVOIR_PICKER_UNIT_ASSERT_SVH
`define WEIGHTED_RESERVOIR_PICKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WRP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WRP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WRP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/wrp_pkg.sv -----
`default_nettype none

package wrp_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int TOTAL_BITS     = 64;
  localparam int MAX_DRAWS      = 64;
  localparam int DRAW_CNT_BITS  = 7;
  localparam int REG_INDEX_BITS = 1;

  localparam logic [REG_INDEX_BITS-1:0] REG_IDX_PRNG_SEED = 1'b0;
  localparam logic [FIELD_BITS-1:0]     COUNT_MAX         = 32'hFFFF_FFFF;

  // One queued item, already masked to the configured widths.
  typedef struct packed {
    logic                  start;
    logic                  wzero;
    logic [FIELD_BITS-1:0] weight;
    logic [FIELD_BITS-1:0] id;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_CALC,
    B_DRAW,
    B_EMIT
  } back_state_t;

  // Sets every bit below the highest set bit, giving 2^n - 1 for bit length n.
  function automatic logic [TOTAL_BITS-1:0] smear64(input logic [TOTAL_BITS-1:0] v);
    logic [TOTAL_BITS-1:0] s;
    s = v;
    for (int i = 0; i < 6; i++) begin
      s = s | (s >> (1 << i));
    end
    return s;
  endfunction

  // Whole-byte mask covering the byte length of v, at least one byte.
  function automatic logic [TOTAL_BITS-1:0] byte_cap_mask(input logic [TOTAL_BITS-1:0] v);
    logic [TOTAL_BITS-1:0] m;
    m = '0;
    for (int k = 0; k <= 7; k++) begin
      if (k == 0 || (v >> (8 * k)) != '0) begin
        m[8*k +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  function automatic logic [TOTAL_BITS-1:0] xorshift64(input logic [TOTAL_BITS-1:0] v);
    logic [TOTAL_BITS-1:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- design/wrp_front.sv -----
`default_nettype none

module wrp_front #(
  parameter int WEIGHT_BITS = 32,
  parameter int ID_BITS     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          start_req,
  input  logic [wrp_pkg::FIELD_BITS-1:0] weight,
  input  logic [wrp_pkg::FIELD_BITS-1:0] item_id,
  output wrp_pkg::item_t                head,
  output logic                          head_valid,
  input  logic                          head_pop
);
  import wrp_pkg::*;

  // Two-entry queue between the input channel and the sequencer.
  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       incoming;

  always_comb begin
    incoming.start  = start_req;
    incoming.weight = FIELD_BITS'(weight[WEIGHT_BITS-1:0]);
    incoming.wzero  = (weight[WEIGHT_BITS-1:0] == '0);
    incoming.id     = FIELD_BITS'(item_id[ID_BITS-1:0]);
  end

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign pop        = head_pop && head_valid;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- design/wrp_back.sv -----
`default_nettype none
`include "weighted_reservoir_picker_unit_assert.svh"

module wrp_back #(
  parameter int WEIGHT_BITS = 32,
  parameter int ID_BITS     = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [wrp_pkg::TOTAL_BITS-1:0] seed,
  input  wrp_pkg::item_t                 head,
  input  logic                           head_valid,
  output logic                           head_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wrp_pkg::FIELD_BITS-1:0] winner_id,
  output logic                           have_winner,
  output logic [wrp_pkg::TOTAL_BITS-1:0] weight_sum,
  output logic [wrp_pkg::FIELD_BITS-1:0] items_seen,
  output logic                           overflow
);
  import wrp_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [TOTAL_BITS-1:0]    total;
  logic [TOTAL_BITS-1:0]    tm1;
  logic [TOTAL_BITS-1:0]    smear_r;
  logic [TOTAL_BITS-1:0]    mask;
  logic [TOTAL_BITS-1:0]    slop;
  logic [TOTAL_BITS-1:0]    prng_word;
  logic [ID_BITS-1:0]       winner_reg;
  logic                     winner_valid;
  logic [FIELD_BITS-1:0]    item_count;
  logic                     ovf;
  logic [WEIGHT_BITS-1:0]   cur_w;
  logic [ID_BITS-1:0]       cur_id;
  logic [DRAW_CNT_BITS-1:0] draw_cnt;

  logic                     out_load;

  // Accumulate step, taken straight from the queue head.
  logic [TOTAL_BITS-1:0]    base_total;
  logic [TOTAL_BITS:0]      sum;
  logic [TOTAL_BITS-1:0]    new_total;
  logic [FIELD_BITS-1:0]    base_count;
  logic [TOTAL_BITS-1:0]    cap_mask;

  // Draw step.
  logic [TOTAL_BITS-1:0]    prng_nxt;
  logic [TOTAL_BITS-1:0]    r;
  logic [TOTAL_BITS:0]      diff;
  logic                     hit;
  logic                     win;
  logic                     last_draw;

  always_comb begin
    base_total = head.start ? '0 : total;
    base_count = head.start ? '0 : item_count;
    sum        = {1'b0, base_total} + (TOTAL_BITS + 1)'(head.weight[WEIGHT_BITS-1:0]);
    new_total  = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    cap_mask   = smear_r & byte_cap_mask(tm1);
    prng_nxt   = xorshift64(prng_word);
    r          = prng_nxt & mask;
    diff       = {1'b0, r} - {1'b0, slop};
    hit        = !diff[TOTAL_BITS];
    win        = hit && (diff[TOTAL_BITS-1:0] < TOTAL_BITS'(cur_w));
    last_draw  = (draw_cnt == DRAW_CNT_BITS'(MAX_DRAWS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        if (head_valid) begin
          head_pop   = 1'b1;
          state_next = head.wzero ? B_EMIT : B_PREP;
        end
      end
      B_PREP: state_next = B_CALC;
      B_CALC: state_next = B_DRAW;
      B_DRAW: begin
        if (hit || last_draw) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      winner_reg   <= '0;
      winner_valid <= 1'b0;
      item_count   <= '0;
      ovf          <= 1'b0;
      prng_word    <= TOTAL_BITS'(1);
    end else begin
      case (state)
        B_IDLE: begin
          if (head_valid) begin
            total      <= new_total;
            ovf        <= (ovf && !head.start) || sum[TOTAL_BITS];
            item_count <= (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
            cur_w      <= head.weight[WEIGHT_BITS-1:0];
            cur_id     <= head.id[ID_BITS-1:0];
            if (head.start) begin
              winner_reg   <= '0;
              winner_valid <= 1'b0;
              prng_word    <= (seed != '0) ? seed : TOTAL_BITS'(1);
            end
          end
        end
        B_PREP: begin
          tm1     <= total - 1'b1;
          smear_r <= smear64(total);
        end
        B_CALC: begin
          mask     <= cap_mask;
          slop     <= cap_mask - tm1;
          draw_cnt <= '0;
        end
        B_DRAW: begin
          prng_word <= prng_nxt;
          draw_cnt  <= draw_cnt + 1'b1;
          if (win) begin
            winner_reg   <= cur_id;
            winner_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: the queue keeps filling while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      winner_id    <= FIELD_BITS'(winner_reg);
      have_winner  <= winner_valid;
      weight_sum   <= total;
      items_seen   <= item_count;
      overflow     <= ovf;
    end
  end

  `WRP_ASSERT_IMP(a_draw_total_nonzero, clk, rst, state == B_DRAW, total != '0)
  `WRP_ASSERT_IMP(a_draw_mask_nonzero, clk, rst, state == B_DRAW, mask[0])
  `WRP_ASSERT_IMP(a_draw_bounded, clk, rst, state == B_DRAW,
                  draw_cnt < DRAW_CNT_BITS'(MAX_DRAWS))
  `WRP_ASSERT_IMP(a_no_winner_clear, clk, rst, !winner_valid, winner_reg == '0)
  `WRP_ASSERT_NXT(a_emit_loads, clk, rst, out_load, out_valid && state == B_IDLE)

endmodule

`default_nettype wire

// ----- design/weighted_reservoir_picker_unit.sv -----
// One item at a time runs through the shared sequencer (accumulate, mask prep, slop,
// draw loop, emit) in wrp_back, which takes the next item only after emitting the last;
// an item of zero weight skips from accumulate straight to emit.
// Reset (rst, synchronous, active high): queue and result emptied, total, count,
// winner and overflow cleared, generator word and seed register set to one.
`default_nettype none

module weighted_reservoir_picker_unit #(
  parameter int WEIGHT_BITS = 32,
  parameter int ID_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [31:0] weight,
  input  logic [31:0] item_id,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] winner_id,
  output logic        have_winner,
  output logic [63:0] weight_sum,
  output logic [31:0] items_seen,
  output logic        overflow
);
  import wrp_pkg::*;

  // The seed register is 64 bits wide, so registers sit on 8-byte slots and
  // paddr[3] selects the register. Only slot zero holds anything.
  logic [TOTAL_BITS-1:0]     prng_seed;
  logic [REG_INDEX_BITS-1:0] reg_index;
  logic                      cfg_write;

  item_t                     head;
  logic                      head_valid;
  logic                      head_pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[3];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_IDX_PRNG_SEED) ? prng_seed : '0;

  // The seed is only copied into the generator when an item with start_req
  // set reaches the sequencer, so a write takes effect at the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      prng_seed <= TOTAL_BITS'(1);
    end else if (cfg_write && reg_index == REG_IDX_PRNG_SEED) begin
      prng_seed <= pwdata;
    end
  end

  // Front end: takes each transfer, masks weight and identifier to their
  // configured widths, flags zero weights and queues the item.
  wrp_front #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ID_BITS     (ID_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_req  (start_req),
    .weight     (weight),
    .item_id    (item_id),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  // Back end: accumulates the total, runs the rejection draws on the
  // xorshift generator, updates the winner and registers the result.
  wrp_back #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .seed         (prng_seed),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winner_id    (winner_id),
    .have_winner  (have_winner),
    .weight_sum   (weight_sum),
    .items_seen   (items_seen),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

// ----- tb/weighted_reservoir_picker_unit_test.sv -----
`timescale 1ns / 100ps

module weighted_reservoir_picker_unit_test;
  import wrp_pkg::*;

  // The seed register is 64 bits wide, so registers sit on 8-byte boundaries.
  // Address 8 decodes to an index with no register behind it, and a write
  // there must leave the seed alone.
  localparam logic [3:0] ADDR_SEED  = {REG_IDX_PRNG_SEED, 3'b000};
  localparam logic [3:0] ADDR_SPARE = {~REG_IDX_PRNG_SEED, 3'b000};

  // The receiver process counts out this many stalled cycles for one hold-off.
  localparam int HOLD_CYCLES    = 300;
  // The longest quiet stretch in a correct run is the hold-off above, so the
  // watchdog limit is set well beyond it.
  localparam int WATCHDOG_LIMIT = 4000;
  // Idle cycles after the last drain, in which no stray result may appear.
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_ITEMS    = 400;

  typedef struct packed {
    logic [31:0] winner_id;
    logic        have_winner;
    logic [63:0] weight_sum;
    logic [31:0] items_seen;
    logic        overflow;
  } pick_result_t;

  // Tracks the picker's state from the transfers it accepts and holds the
  // results that are still owed.
  class reservoir_tracker;
    logic [63:0]  seed_reg;
    logic [63:0]  rng_word;
    logic [63:0]  running_sum;
    logic [31:0]  champion;
    logic         champion_valid;
    logic [31:0]  seen_count;
    logic         sum_wrapped;
    pick_result_t owed_picks[$];
    int           errors;
    int           items;
    int           results;
    int           runs;
    int           takeovers;

    function new();
      seed_reg       = 64'd1;
      rng_word       = 64'd1;
      running_sum    = '0;
      champion       = '0;
      champion_valid = 1'b0;
      seen_count     = '0;
      sum_wrapped    = 1'b0;
      errors         = 0;
      items          = 0;
      results        = 0;
      runs           = 0;
      takeovers      = 0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [63:0] data);
      if (addr[3] == REG_IDX_PRNG_SEED) begin
        seed_reg = data;
      end
    endfunction

    function logic [63:0] next_random();
      logic [63:0] x;
      x = rng_word;
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      rng_word = x;
      return x;
    endfunction

    // Uniform value below limit by masking to the bit length of limit, capped at the
    // byte length of limit - 1, and rejecting values below the slop 2^n - limit.
    function bit uniform_below(logic [63:0] limit, output logic [63:0] pick);
      int          nbits;
      int          cap;
      logic [63:0] v;
      logic [63:0] mask;
      logic [63:0] span;
      logic [63:0] slop;
      logic [63:0] r;
      nbits = 0;
      v = limit;
      while (v != 0) begin
        nbits++;
        v = v >> 1;
      end
      cap = 8;
      v = (limit - 64'd1) >> 8;
      while (v != 0) begin
        cap += 8;
        v = v >> 8;
      end
      if (nbits > cap) begin
        nbits = cap;
      end
      if (nbits >= 64) begin
        mask = '1;
        span = '0;
      end else begin
        span = 64'd1 << nbits;
        mask = span - 64'd1;
      end
      slop = span - limit;
      pick = '0;
      for (int i = 0; i < MAX_DRAWS; i++) begin
        r = next_random() & mask;
        if (r >= slop) begin
          pick = r - slop;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(logic start, logic [31:0] w, logic [31:0] id);
      logic [64:0]  sum;
      logic [63:0]  pick;
      pick_result_t exp_pick;
      items++;
      if (start) begin
        runs++;
        running_sum    = '0;
        champion       = '0;
        champion_valid = 1'b0;
        seen_count     = '0;
        sum_wrapped    = 1'b0;
        rng_word       = (seed_reg != 0) ? seed_reg : 64'd1;
      end
      if (w != 0) begin
        sum = {1'b0, running_sum} + {33'd0, w};
        if (sum[64]) begin
          sum_wrapped = 1'b1;
          running_sum = '1;
        end else begin
          running_sum = sum[63:0];
        end
        if (uniform_below(running_sum, pick) && pick < {32'd0, w}) begin
          champion       = id;
          champion_valid = 1'b1;
          takeovers++;
        end
      end
      if (seen_count != COUNT_MAX) begin
        seen_count++;
      end
      exp_pick.winner_id    = champion;
      exp_pick.have_winner  = champion_valid;
      exp_pick.weight_sum   = running_sum;
      exp_pick.items_seen   = seen_count;
      exp_pick.overflow     = sum_wrapped;
      owed_picks.push_back(exp_pick);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_pick(pick_result_t got);
      pick_result_t exp_pick;
      results++;
      if (owed_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      exp_pick = owed_picks.pop_front();
      compare_field("winner_id", 64'(exp_pick.winner_id), 64'(got.winner_id));
      compare_field("have_winner", 64'(exp_pick.have_winner), 64'(got.have_winner));
      compare_field("weight_sum", exp_pick.weight_sum, got.weight_sum);
      compare_field("items_seen", 64'(exp_pick.items_seen), 64'(got.items_seen));
      compare_field("overflow", 64'(exp_pick.overflow), 64'(got.overflow));
    endfunction

    function int owed();
      return owed_picks.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        start_req;
  logic [31:0] weight;
  logic [31:0] item_id;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] winner_id;
  logic        have_winner;
  logic [63:0] weight_sum;
  logic [31:0] items_seen;
  logic        overflow;

  reservoir_tracker picks;

  // Idle rates in percent of cycles, changed from phase to phase.
  int recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req;
  int quiet_cycles;

  weighted_reservoir_picker_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_req    (start_req),
    .weight       (weight),
    .item_id      (item_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winner_id    (winner_id),
    .have_winner  (have_winner),
    .weight_sum   (weight_sum),
    .items_seen   (items_seen),
    .overflow     (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one item and holds it until the picker takes the transfer. The
  // caller is at a rising edge, so valid is raised with a single assignment
  // even when it was already high for the previous item.
  task automatic send_item(input logic s, input logic [31:0] w, input logic [31:0] id);
    in_valid  <= 1'b1;
    start_req <= s;
    weight    <= w;
    item_id   <= id;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    picks.note_item(s, w, id);
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (picks.owed() != 0) begin
      @(posedge clk);
    end
  endtask

  // Setup cycle, then the access cycle; pready is always high, so the write
  // lands at the edge that ends the access cycle.
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    picks.write_reg(addr, data);
  endtask

  // Random traffic. Most items come in well-formed runs that open with a
  // start request and carry a mix of zero, byte-sized, 16-bit and full-width
  // weights, so totals cross many bit lengths. A few stray start requests
  // break runs at odd places.
  task automatic run_phase(input int send_idle_pct, input int hold_at, input int pause_at);
    int          run_left;
    int          sel;
    logic        s;
    logic [31:0] w;
    run_left = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if (n == hold_at) begin
        hold_req = 1'b1;
      end
      if (n == pause_at) begin
        drain();
      end
      if (run_left == 0) begin
        s = 1'b1;
        run_left = $urandom_range(4, 40);
      end else begin
        s = ($urandom_range(0, 99) < 3);
        run_left--;
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        w = '0;
      end else if (sel < 45) begin
        w = $urandom_range(1, 255);
      end else if (sel < 70) begin
        w = $urandom_range(1, 65535);
      end else begin
        w = $urandom();
      end
      send_item(s, w, $urandom());
    end
    drain();
  endtask

  // Result side: checks each accepted transfer against the oldest owed
  // result, then decides the stall for the next cycle. A hold-off request
  // is counted down here so the sender keeps offering items meanwhile and
  // the picker backs up into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        picks.check_pick({winner_id, have_winner, weight_sum, items_seen, overflow});
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    picks         = new();
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    start_req     = 1'b0;
    weight        = '0;
    item_id       = '0;
    out_stall     = 1'b0;
    recv_idle_pct = 0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first item runs on the reset state without a start
    // request, so the generator starts from one and the seed is not loaded.
    send_item(1'b0, 32'd5, 32'h0000_0001);
    send_item(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(1'b0, 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_item(1'b0, 32'h8000_0000, 32'hA5A5_A5A5);
    // A lone item of weight one always wins, with the smallest possible draw.
    send_item(1'b1, 32'd1, 32'd1);
    send_item(1'b0, 32'd1, 32'd2);
    send_item(1'b0, 32'd0, 32'd3);
    send_item(1'b0, 32'h0000_00FF, 32'd4);
    send_item(1'b0, 32'h0000_0100, 32'd5);
    drain();

    // A zero seed must be loaded as one, since the generator cannot hold zero.
    write_reg(ADDR_SEED, 64'd0);
    send_item(1'b1, 32'd3, 32'd6);
    send_item(1'b0, 32'd7, 32'd7);
    drain();

    // A write beyond the only register is ignored.
    write_reg(ADDR_SPARE, 64'hDEAD_BEEF_0123_4567);
    send_item(1'b1, 32'd2, 32'd8);
    send_item(1'b0, 32'd9, 32'd9);
    drain();

    write_reg(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF, 32'h0000_000A);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_000B);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h0000_000C);
    drain();

    // Sender idles lightly, receiver heavily; midway the sender waits for
    // every owed result before going on.
    write_reg(ADDR_SEED, {$urandom(), $urandom()} | 64'd1);
    recv_idle_pct = 61;
    run_phase(10, -1, 200);

    // The other way round, with one long receiver hold-off.
    write_reg(ADDR_SEED, {$urandom(), $urandom()});
    recv_idle_pct = 10;
    run_phase(61, 150, -1);

    // Back to back on both sides, seeded with one.
    write_reg(ADDR_SEED, 64'd1);
    recv_idle_pct = 0;
    run_phase(0, -1, -1);

    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    picks.errors += picks.owed();

    $display("Covered %0d item transfers in %0d runs with %0d winner changes,",
             picks.items, picks.runs, picks.takeovers);
    $display("checking %0d results over four seeds and three idle patterns.", picks.results);
    if (picks.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
